/* hw/rtl/lirs_pkg.sv */
package lirs_pkg;

   localparam int unsigned SAMPLE_W         = 16;
   localparam int unsigned RATE_W           = 18;
   localparam int unsigned CREDIT_W         = 24;
   localparam int unsigned MAX_RESULTS      = 33;
   localparam int unsigned CNT_W            = $clog2(MAX_RESULTS + 1);
   localparam int unsigned MAX_UP_RATIO_DEF = 16;

   localparam int unsigned PROD_W   = SAMPLE_W + RATE_W + 1;
   localparam int unsigned ACC_W    = PROD_W + 1;
   localparam int unsigned QUO_W    = SAMPLE_W;
   localparam int unsigned MAG_W    = QUO_W + RATE_W;
   localparam int unsigned DSTEP_W  = $clog2(QUO_W);

   localparam int unsigned PDATA_W  = 32;
   localparam int unsigned PADDR_W  = 3;

   localparam logic [CREDIT_W-1:0] CREDIT_MAX = {CREDIT_W{1'b1}};

   localparam logic [RATE_W-1:0] IN_RATE_RESET  = RATE_W'(44100);
   localparam logic [RATE_W-1:0] OUT_RATE_RESET = RATE_W'(16000);

   // Register select is the word address bit of paddr.
   localparam logic REG_IN_RATE  = 1'b0;
   localparam logic REG_OUT_RATE = 1'b1;

endpackage

/* hw/rtl/lirs_if.sv */
interface lirs_req_if import lirs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic                       last_in;

   modport source (output valid, output sample_in, output last_in, input ready);
   modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface lirs_rsp_if import lirs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       run_last;
   logic                       stream_end;

   modport source (output valid, output sample_out, output run_last, output stream_end,
                   input ready);
   modport sink   (input valid, input sample_out, input run_last, input stream_end,
                   output ready);
endinterface

/* hw/rtl/linear_interp_resampler_core.sv */
// Linear interpolation sample rate converter for Q1.15 audio.
// The req channel takes one input sample per beat, with last_in marking the end of
// a stream. Each input beat gives zero or more rsp beats; run_last marks the final
// beat caused by an input, and stream_end the final beat of the whole stream.
// in_rate and out_rate are written over the APB port at byte addresses 0 and 4;
// out_rate is clamped to MAX_UP_RATIO times in_rate, and a zero rate acts as one.
// One item is worked on at a time and req_ready is high only while the block is
// idle. Each interpolated output is computed through a single shared multiplier
// and a 16-step restoring divider. After an accepted beat req_ready stays low
// while the beat computes its k (at most MAX_UP_RATIO) interpolated outputs,
// none for the first beat of a stream; a final input also emits repeated outputs
// of its sample. Results pass through a one-deep pending stage into the output
// register; when the receiver stalls, the sequencer waits at the next result and
// no beat is lost. Synchronous reset loads the rate defaults (44100 and 16000),
// clears all stream state and empties the output register.
module linear_interp_resampler_core import lirs_pkg::*; #(
   parameter int unsigned MAX_UP_RATIO = MAX_UP_RATIO_DEF
) (
   input  logic               clock,
   input  logic               reset,
   lirs_req_if.sink           req_chan,
   lirs_rsp_if.source         rsp_chan,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready
);

   localparam int unsigned CAP_W = RATE_W + $clog2(MAX_UP_RATIO + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_HELD  = 4'd1;
   localparam logic [3:0] S_LOOP  = 4'd2;
   localparam logic [3:0] S_MUL1  = 4'd3;
   localparam logic [3:0] S_MUL2  = 4'd4;
   localparam logic [3:0] S_SUM   = 4'd5;
   localparam logic [3:0] S_PREP  = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_PUT   = 4'd8;
   localparam logic [3:0] S_TAIL  = 4'd9;
   localparam logic [3:0] S_LHELD = 4'd10;
   localparam logic [3:0] S_LREP  = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   logic [RATE_W-1:0] in_rate_ff, in_rate_in;
   logic [RATE_W-1:0] out_rate_ff, out_rate_in;

   logic [3:0] state_ff, state_in;

   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic                       last_ff, last_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                       have_prev_ff, have_prev_in;
   logic [RATE_W:0]            phase_ff, phase_in;
   logic [CREDIT_W-1:0]        credit_ff, credit_in;
   logic signed [SAMPLE_W-1:0] held_ff, held_in;
   logic                       held_valid_ff, held_valid_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;

   logic signed [SAMPLE_W-1:0] pend_ff, pend_in;
   logic                       pend_valid_ff, pend_valid_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_run_last_ff, rsp_run_last_in;
   logic                       rsp_stream_end_ff, rsp_stream_end_in;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     neg_ff, neg_in;
   logic [RATE_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [DSTEP_W-1:0]       dstep_ff, dstep_in;

   logic [RATE_W-1:0]        ir;
   logic [RATE_W-1:0]        o_nz;
   logic [CAP_W-1:0]         cap;
   logic [RATE_W-1:0]        orr;
   logic                     credit_ge;
   logic                     out_free;
   logic                     can_emit;
   logic                     emit_go;
   logic signed [SAMPLE_W-1:0] emit_val;
   logic                     take_go;
   logic signed [SAMPLE_W-1:0] mul_a;
   logic [RATE_W-1:0]        mul_b;
   logic signed [PROD_W-1:0] mult;
   logic [CREDIT_W:0]        credit_sum;
   logic [ACC_W-1:0]         acc_abs;
   logic [MAG_W-1:0]         mag;
   logic [RATE_W:0]          trial;
   logic [SAMPLE_W-1:0]      interp_val;
   logic                     req_fire;
   logic                     csr_write;

   assign ir   = (in_rate_ff == '0) ? RATE_W'(1) : in_rate_ff;
   assign o_nz = (out_rate_ff == '0) ? RATE_W'(1) : out_rate_ff;
   assign cap  = CAP_W'(ir) * CAP_W'(MAX_UP_RATIO);
   assign orr  = (CAP_W'(o_nz) > cap) ? cap[RATE_W-1:0] : o_nz;

   assign credit_ge = credit_ff >= CREDIT_W'(ir);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign can_emit  = (cnt_ff >= CNT_W'(MAX_RESULTS)) || !pend_valid_ff || out_free;

   assign mult = mul_a * $signed({1'b0, mul_b});

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.run_last   = rsp_run_last_ff;
   assign rsp_chan.stream_end = rsp_stream_end_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         REG_IN_RATE:  csr_prdata = PDATA_W'(in_rate_ff);
         REG_OUT_RATE: csr_prdata = PDATA_W'(out_rate_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_comb begin
      in_rate_in  = in_rate_ff;
      out_rate_in = out_rate_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_IN_RATE:  in_rate_in  = csr_pwdata[RATE_W-1:0];
            REG_OUT_RATE: out_rate_in = csr_pwdata[RATE_W-1:0];
            default:      in_rate_in  = in_rate_ff;
         endcase
      end
   end

   always_comb begin
      state_in          = state_ff;
      x_in              = x_ff;
      last_in           = last_ff;
      prev_in           = prev_ff;
      have_prev_in      = have_prev_ff;
      phase_in          = phase_ff;
      credit_in         = credit_ff;
      held_in           = held_ff;
      held_valid_in     = held_valid_ff;
      cnt_in            = cnt_ff;
      pend_in           = pend_ff;
      pend_valid_in     = pend_valid_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_sample_in     = rsp_sample_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_stream_end_in = rsp_stream_end_ff;
      prod_in           = prod_ff;
      acc_in            = acc_ff;
      neg_in            = neg_ff;
      rem_in            = rem_ff;
      quo_in            = quo_ff;
      dstep_in          = dstep_ff;
      emit_go           = 1'b0;
      emit_val          = x_ff;
      take_go           = 1'b0;
      mul_a             = prev_ff;
      mul_b             = orr - phase_ff[RATE_W-1:0];
      credit_sum        = {1'b0, credit_ff} + (CREDIT_W + 1)'(orr);
      acc_abs           = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      mag               = acc_abs[MAG_W-1:0] + MAG_W'(orr >> 1);
      trial             = {rem_ff, quo_ff[QUO_W-1]};
      interp_val        = neg_ff ? SAMPLE_W'(-quo_ff) : SAMPLE_W'(quo_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               x_in      = req_chan.sample_in;
               last_in   = req_chan.last_in;
               cnt_in    = '0;
               credit_in = credit_sum[CREDIT_W] ? CREDIT_MAX : credit_sum[CREDIT_W-1:0];
               state_in  = S_HELD;
            end
         end
         S_HELD: begin
            if (held_valid_ff && credit_ge) begin
               if (can_emit) begin
                  take_go       = 1'b1;
                  emit_go       = 1'b1;
                  emit_val      = held_ff;
                  held_valid_in = 1'b0;
                  state_in      = have_prev_ff ? S_LOOP : S_TAIL;
               end
            end else begin
               state_in = have_prev_ff ? S_LOOP : S_TAIL;
            end
         end
         S_LOOP: begin
            if (phase_ff < {1'b0, orr}) begin
               state_in = S_MUL1;
            end else begin
               phase_in = {1'b0, RATE_W'(phase_ff - {1'b0, orr})};
               state_in = S_TAIL;
            end
         end
         S_MUL1: begin
            prod_in  = mult;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            mul_a    = x_ff;
            mul_b    = phase_ff[RATE_W-1:0];
            prod_in  = mult;
            acc_in   = ACC_W'(prod_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            acc_in   = acc_ff + ACC_W'(prod_ff);
            state_in = S_PREP;
         end
         S_PREP: begin
            neg_in   = acc_ff[ACC_W-1];
            rem_in   = mag[MAG_W-1:QUO_W];
            quo_in   = mag[QUO_W-1:0];
            dstep_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (trial >= {1'b0, orr}) begin
               rem_in = RATE_W'(trial - {1'b0, orr});
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[RATE_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            dstep_in = dstep_ff + DSTEP_W'(1);
            if (dstep_ff == DSTEP_W'(QUO_W - 1)) begin
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            if (!held_valid_ff && credit_ge) begin
               if (can_emit) begin
                  take_go  = 1'b1;
                  emit_go  = 1'b1;
                  emit_val = interp_val;
                  phase_in = phase_ff + (RATE_W + 1)'(ir);
                  state_in = S_LOOP;
               end
            end else begin
               held_in       = interp_val;
               held_valid_in = 1'b1;
               phase_in      = phase_ff + (RATE_W + 1)'(ir);
               state_in      = S_LOOP;
            end
         end
         S_TAIL: begin
            prev_in      = x_ff;
            have_prev_in = 1'b1;
            state_in     = last_ff ? S_LHELD : S_FIN;
         end
         S_LHELD: begin
            if (held_valid_ff && credit_ge) begin
               if (can_emit) begin
                  take_go  = 1'b1;
                  emit_go  = 1'b1;
                  emit_val = held_ff;
                  state_in = S_LREP;
               end
            end else begin
               state_in = S_LREP;
            end
         end
         S_LREP: begin
            if (cnt_ff < CNT_W'(MAX_RESULTS) && credit_ge) begin
               if (can_emit) begin
                  take_go  = 1'b1;
                  emit_go  = 1'b1;
                  emit_val = x_ff;
               end
            end else begin
               prev_in       = '0;
               have_prev_in  = 1'b0;
               phase_in      = '0;
               held_in       = '0;
               held_valid_in = 1'b0;
               state_in      = S_FIN;
            end
         end
         S_FIN: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  rsp_valid_in      = 1'b1;
                  rsp_sample_in     = pend_ff;
                  rsp_run_last_in   = 1'b1;
                  rsp_stream_end_in = last_ff;
                  pend_valid_in     = 1'b0;
                  state_in          = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (take_go) begin
         credit_in = credit_ff - CREDIT_W'(ir);
      end
      if (state_ff == S_LREP && !(cnt_ff < CNT_W'(MAX_RESULTS) && credit_ge)) begin
         credit_in = '0;
      end

      // The newest result waits in the pending stage until it is known
      // whether another one follows it from the same input beat.
      if (emit_go && cnt_ff < CNT_W'(MAX_RESULTS)) begin
         if (pend_valid_ff) begin
            rsp_valid_in      = 1'b1;
            rsp_sample_in     = pend_ff;
            rsp_run_last_in   = 1'b0;
            rsp_stream_end_in = 1'b0;
         end
         pend_in       = emit_val;
         pend_valid_in = 1'b1;
         cnt_in        = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rate_ff    <= IN_RATE_RESET;
         out_rate_ff   <= OUT_RATE_RESET;
         state_ff      <= S_IDLE;
         have_prev_ff  <= 1'b0;
         phase_ff      <= '0;
         credit_ff     <= '0;
         held_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         prev_ff       <= '0;
         held_ff       <= '0;
      end else begin
         in_rate_ff    <= in_rate_in;
         out_rate_ff   <= out_rate_in;
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         phase_ff      <= phase_in;
         credit_ff     <= credit_in;
         held_valid_ff <= held_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         prev_ff       <= prev_in;
         held_ff       <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff              <= x_in;
      last_ff           <= last_in;
      pend_ff           <= pend_in;
      rsp_sample_ff     <= rsp_sample_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_stream_end_ff <= rsp_stream_end_in;
      prod_ff           <= prod_in;
      acc_ff            <= acc_in;
      neg_ff            <= neg_in;
      rem_ff            <= rem_in;
      quo_ff            <= quo_in;
      dstep_ff          <= dstep_in;
   end

endmodule

/* hw/rtl/lirs_checker.sv */
module lirs_checker import lirs_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input logic                       rsp_run_last,
   input logic                       rsp_stream_end
);

   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result beat offered straight after reset.");

   a_rsp_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_run_last) && $stable(rsp_stream_end))
      else $error("Stalled result beat changed or vanished.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Input taken again while the previous one is still in work.");

   a_stream_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_run_last)
      else $error("Stream end marked on a beat that is not the last of its input.");

endmodule

bind linear_interp_resampler_core lirs_checker u_lirs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_sample_out (rsp_chan.sample_out),
   .rsp_run_last   (rsp_chan.run_last),
   .rsp_stream_end (rsp_chan.stream_end)
);
